[sv/efu_pkg.sv]
`timescale 1ns / 1ps

package efu_pkg;

  // Shared unit operand widths
  localparam int unsigned MUL_A_W = 64;
  localparam int unsigned MUL_B_W = 40;
  localparam int unsigned DIV_N_W = 64;
  localparam int unsigned DIV_D_W = 40;

  // Constants (Q.32 unless noted; ONE_Q24 is Q.24, the limits are Q4.12)
  localparam logic [32:0] ONE_Q32         = 33'h1_0000_0000;
  localparam logic [32:0] TWO_OVER_SQRTPI = 33'd4846351620;
  localparam logic [24:0] ONE_Q24         = 25'h100_0000;
  localparam logic [29:0] BILLION         = 30'd1000000000;
  localparam logic [15:0] LIMIT_SERIES    = 16'd12288;
  localparam logic [15:0] LIMIT_FIT       = 16'd24576;
  localparam logic [4:0]  EXP_TERMS       = 5'd16;

  // Rational fit coefficients in units of 1e-9; entries 0..2 for the
  // middle range, entries 3..4 for the far range
  localparam int unsigned FIT_N = 5;
  localparam logic [2:0] FIT_MID_FIRST = 3'd0;
  localparam logic [2:0] FIT_MID_LAST  = 3'd2;
  localparam logic [2:0] FIT_FAR_FIRST = 3'd3;
  localparam logic [2:0] FIT_FAR_LAST  = 3'd4;
  localparam logic [28:0] FIT_NUM [FIT_N] = '{
    29'd461313500, 29'd99992160, 29'd2883894, 29'd512424200, 29'd51765360
  };
  localparam logic [32:0] FIT_DEN [FIT_N] = '{
    33'd190163500, 33'd1784492700, 33'd5525343700, 33'd275255100, 33'd2724745000
  };

endpackage

[sv/efu_mul.sv]
`timescale 1ns / 1ps

module efu_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          go_i,
  input  logic [efu_pkg::MUL_A_W-1:0]   a_i,
  input  logic [efu_pkg::MUL_B_W-1:0]   b_i,
  output logic                          done_o,
  output logic [efu_pkg::MUL_A_W-1:0]   p_o
);

  logic [efu_pkg::MUL_A_W-1:0] a_q;
  logic [efu_pkg::MUL_B_W-1:0] b_q;
  logic [efu_pkg::MUL_A_W-1:0] acc_q;
  logic                        busy_q;
  logic                        done_q;

  // Add one 4-bit digit of b per cycle, stop once b runs out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      b_q    <= '0;
      acc_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        a_q    <= a_i;
        b_q    <= b_i;
        acc_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (b_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          acc_q <= acc_q + (a_q * efu_pkg::MUL_A_W'(b_q[3:0]));
          a_q   <= a_q << 4;
          b_q   <= b_q >> 4;
        end
      end
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

[sv/efu_div.sv]
`timescale 1ns / 1ps

module efu_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          go_i,
  input  logic [efu_pkg::DIV_N_W-1:0]   n_i,
  input  logic [efu_pkg::DIV_D_W-1:0]   d_i,
  output logic                          done_o,
  output logic [efu_pkg::DIV_N_W-1:0]   q_o
);

  localparam int unsigned CntW = $clog2(efu_pkg::DIV_N_W + 1);

  logic [efu_pkg::DIV_D_W-1:0] rem_q;
  logic [efu_pkg::DIV_N_W-1:0] quo_q;
  logic [efu_pkg::DIV_D_W-1:0] den_q;
  logic [CntW-1:0]             cnt_q;
  logic                        busy_q;
  logic                        done_q;
  logic [efu_pkg::DIV_D_W:0]   trial;
  logic [efu_pkg::DIV_D_W:0]   diff;
  logic                        fits;

  // Trial subtract of the shifted remainder
  always_comb begin
    trial = {rem_q, quo_q[efu_pkg::DIV_N_W-1]};
    diff  = trial - {1'b0, den_q};
    fits  = trial >= {1'b0, den_q};
  end

  // One quotient bit per cycle, restoring
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        rem_q  <= '0;
        quo_q  <= n_i;
        den_q  <= d_i;
        cnt_q  <= CntW'(efu_pkg::DIV_N_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= fits ? diff[efu_pkg::DIV_D_W-1:0] : trial[efu_pkg::DIV_D_W-1:0];
        quo_q <= {quo_q[efu_pkg::DIV_N_W-2:0], fits};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign q_o    = quo_q;

endmodule

[sv/error_function_unit.sv]
`timescale 1ns / 1ps
// Channel  Signals                                    Dir  Meaning
// in       in_valid_i, in_stall_o, argument_i,         in   x in Q4.12, erf/erfc select
//          complementary_i
// out      out_valid_o, out_stall_i, value_o           out  erf or erfc in Q2.16
//
// One item at a time, sequenced through the shared restoring divider
// (two 16-term exponential sums, up to 47 series terms) and
// the 4-bit-per-cycle shared multiplier (power steps end once the whole part is used up or e underflows).
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops out_valid_o.
// in_stall_o is high while an item is in work; a held result in the output
// register does not stall the input until the next result is ready.

module error_function_unit #(
  parameter int unsigned SERIES_TERMS = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] argument_i,
  input  logic               complementary_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [17:0] value_o
);

  localparam int unsigned KW = $clog2(SERIES_TERMS);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_EXP_MUL, S_EXP_DIV, S_POW_CHK, S_POW, S_R0A, S_R0B,
    S_SER_MUL, S_SER_DIV, S_ZB, S_FIT_DIV, S_W1, S_W2, S_OUT
  } state_e;

  state_e state_q;

  logic [15:0]        ax_q;
  logic               xneg_q;
  logic               xpos_q;
  logic               comp_q;
  logic [30:0]        z_q;
  logic               run_q;
  logic signed [35:0] sum_q;
  logic [4:0]         ek_q;
  logic [32:0]        e1_q;
  logic [32:0]        e_q;
  logic [6:0]         whole_q;
  logic [33:0]        r_q;
  logic [34:0]        s_q;
  logic [KW-1:0]      k_q;
  logic [36:0]        zb_q;
  logic [37:0]        rat_q;
  logic [2:0]         fi_q;
  logic signed [36:0] v_q;
  logic               out_valid_q;
  logic signed [17:0] value_q;

  logic                         mul_go_q;
  logic [efu_pkg::MUL_A_W-1:0]  mul_a_q;
  logic [efu_pkg::MUL_B_W-1:0]  mul_b_q;
  logic                         mul_done;
  logic [efu_pkg::MUL_A_W-1:0]  mul_p;
  logic                         div_go_q;
  logic [efu_pkg::DIV_N_W-1:0]  div_n_q;
  logic [efu_pkg::DIV_D_W-1:0]  div_d_q;
  logic                         div_done;
  logic [efu_pkg::DIV_N_W-1:0]  div_q;

  efu_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (mul_go_q),
    .a_i    (mul_a_q),
    .b_i    (mul_b_q),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  efu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (div_go_q),
    .n_i    (div_n_q),
    .d_i    (div_d_q),
    .done_o (div_done),
    .q_o    (div_q)
  );

  // Datapath helpers around the shared units
  logic [15:0]        ax_in;
  logic [efu_pkg::MUL_B_W-1:0] f_cur;
  logic [32:0]        t_n;
  logic signed [35:0] sum_n;
  logic [32:0]        ex_n;
  logic [33:0]        r_n;
  logic [34:0]        s_n;
  logic signed [36:0] se_n;
  logic signed [36:0] v_ser;
  logic [36:0]        zb_n;
  logic [37:0]        rat_n;
  logic [36:0]        w_n;
  logic signed [36:0] v_fit;
  logic [2:0]         fi_first;
  logic [36:0]        mag;
  logic [20:0]        rq;
  logic signed [17:0] value_n;
  logic signed [36:0] one37;

  always_comb begin
    one37    = 37'(efu_pkg::ONE_Q32);
    ax_in    = argument_i[15] ? 16'(-argument_i) : 16'(argument_i);
    f_cur    = run_q ? efu_pkg::MUL_B_W'(z_q[23:0]) : efu_pkg::MUL_B_W'(efu_pkg::ONE_Q24);
    t_n      = div_q[32:0];
    sum_n    = ek_q[0] ? sum_q - 36'(t_n) : sum_q + 36'(t_n);
    ex_n     = sum_n[35] ? '0 : sum_n[32:0];
    r_n      = div_q[33:0];
    s_n      = s_q + 35'(r_n);
    se_n     = xneg_q ? -37'(s_n) : 37'(s_n);
    v_ser    = comp_q ? one37 - se_n : se_n;
    zb_n     = mul_p[60:24];
    rat_n    = rat_q + div_q[37:0];
    w_n      = mul_p[48:12];
    fi_first = (ax_q <= efu_pkg::LIMIT_FIT) ? efu_pkg::FIT_MID_FIRST : efu_pkg::FIT_FAR_FIRST;
    if (xpos_q) begin
      v_fit = comp_q ? $signed(w_n) : one37 - $signed(w_n);
    end else begin
      v_fit = comp_q ? (one37 <<< 1) - $signed(w_n) : $signed(w_n) - one37;
    end
    // Round to Q2.16, ties away from zero, saturate
    mag = v_q[36] ? 37'(-v_q) : 37'(v_q);
    rq  = 21'((mag + 37'd32768) >> 16);
    if (!v_q[36]) begin
      value_n = (rq > 21'd131071) ? 18'sd131071 : $signed(rq[17:0]);
    end else begin
      value_n = (rq > 21'd131072) ? -18'sd131072 : -$signed(rq[17:0]);
    end
  end

  // Sequence the item through the shared multiplier and divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ax_q        <= '0;
      xneg_q      <= 1'b0;
      xpos_q      <= 1'b0;
      comp_q      <= 1'b0;
      z_q         <= '0;
      run_q       <= 1'b0;
      sum_q       <= '0;
      ek_q        <= '0;
      e1_q        <= '0;
      e_q         <= '0;
      whole_q     <= '0;
      r_q         <= '0;
      s_q         <= '0;
      k_q         <= '0;
      zb_q        <= '0;
      rat_q       <= '0;
      fi_q        <= '0;
      v_q         <= '0;
      out_valid_q <= 1'b0;
      value_q     <= '0;
      mul_go_q    <= 1'b0;
      mul_a_q     <= '0;
      mul_b_q     <= '0;
      div_go_q    <= 1'b0;
      div_n_q     <= '0;
      div_d_q     <= '0;
    end else begin
      mul_go_q <= 1'b0;
      div_go_q <= 1'b0;
      if (out_valid_q && !out_stall_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            ax_q     <= ax_in;
            xneg_q   <= argument_i[15];
            xpos_q   <= !argument_i[15] && (argument_i != '0);
            comp_q   <= complementary_i;
            mul_a_q  <= efu_pkg::MUL_A_W'(ax_in);
            mul_b_q  <= efu_pkg::MUL_B_W'(ax_in);
            mul_go_q <= 1'b1;
            state_q  <= S_SQ;
          end
        end
        S_SQ: begin
          // Start e^-1 first
          if (mul_done) begin
            z_q      <= mul_p[30:0];
            run_q    <= 1'b0;
            sum_q    <= 36'(efu_pkg::ONE_Q32);
            ek_q     <= 5'd1;
            mul_a_q  <= efu_pkg::MUL_A_W'(efu_pkg::ONE_Q32);
            mul_b_q  <= efu_pkg::MUL_B_W'(efu_pkg::ONE_Q24);
            mul_go_q <= 1'b1;
            state_q  <= S_EXP_MUL;
          end
        end
        S_EXP_MUL: begin
          if (mul_done) begin
            div_n_q  <= mul_p >> 24;
            div_d_q  <= efu_pkg::DIV_D_W'(ek_q);
            div_go_q <= 1'b1;
            state_q  <= S_EXP_DIV;
          end
        end
        S_EXP_DIV: begin
          if (div_done) begin
            if (ek_q == efu_pkg::EXP_TERMS) begin
              if (!run_q) begin
                // e^-1 done, now e^-f
                e1_q     <= ex_n;
                run_q    <= 1'b1;
                sum_q    <= 36'(efu_pkg::ONE_Q32);
                ek_q     <= 5'd1;
                mul_a_q  <= efu_pkg::MUL_A_W'(efu_pkg::ONE_Q32);
                mul_b_q  <= efu_pkg::MUL_B_W'(z_q[23:0]);
                mul_go_q <= 1'b1;
                state_q  <= S_EXP_MUL;
              end else begin
                e_q     <= ex_n;
                whole_q <= z_q[30:24];
                state_q <= S_POW_CHK;
              end
            end else begin
              sum_q    <= sum_n;
              ek_q     <= ek_q + 5'd1;
              mul_a_q  <= efu_pkg::MUL_A_W'(t_n);
              mul_b_q  <= f_cur;
              mul_go_q <= 1'b1;
              state_q  <= S_EXP_MUL;
            end
          end
        end
        S_POW_CHK: begin
          mul_go_q <= 1'b1;
          if (whole_q != '0 && e_q != '0) begin
            mul_a_q <= efu_pkg::MUL_A_W'(e_q);
            mul_b_q <= efu_pkg::MUL_B_W'(e1_q);
            state_q <= S_POW;
          end else if (ax_q <= efu_pkg::LIMIT_SERIES) begin
            mul_a_q <= efu_pkg::MUL_A_W'(ax_q);
            mul_b_q <= efu_pkg::MUL_B_W'(e_q);
            state_q <= S_R0A;
          end else begin
            mul_a_q <= efu_pkg::MUL_A_W'(z_q);
            mul_b_q <= efu_pkg::MUL_B_W'(efu_pkg::BILLION);
            state_q <= S_ZB;
          end
        end
        S_POW: begin
          if (mul_done) begin
            e_q     <= 33'(mul_p[63:32]);
            whole_q <= whole_q - 7'd1;
            state_q <= S_POW_CHK;
          end
        end
        S_R0A: begin
          if (mul_done) begin
            mul_a_q  <= mul_p >> 12;
            mul_b_q  <= efu_pkg::MUL_B_W'(efu_pkg::TWO_OVER_SQRTPI);
            mul_go_q <= 1'b1;
            state_q  <= S_R0B;
          end
        end
        S_R0B: begin
          if (mul_done) begin
            r_q      <= 34'(mul_p[63:32]);
            s_q      <= 35'(mul_p[63:32]);
            k_q      <= KW'(1);
            mul_a_q  <= efu_pkg::MUL_A_W'(mul_p[63:32]);
            mul_b_q  <= efu_pkg::MUL_B_W'({z_q, 1'b0});
            mul_go_q <= 1'b1;
            state_q  <= S_SER_MUL;
          end
        end
        S_SER_MUL: begin
          if (mul_done) begin
            div_n_q  <= mul_p >> 24;
            div_d_q  <= efu_pkg::DIV_D_W'({k_q, 1'b1});
            div_go_q <= 1'b1;
            state_q  <= S_SER_DIV;
          end
        end
        S_SER_DIV: begin
          if (div_done) begin
            s_q <= s_n;
            if (k_q == KW'(SERIES_TERMS - 1)) begin
              v_q     <= v_ser;
              state_q <= S_OUT;
            end else begin
              r_q      <= r_n;
              k_q      <= k_q + 1'b1;
              mul_a_q  <= efu_pkg::MUL_A_W'(r_n);
              mul_b_q  <= efu_pkg::MUL_B_W'({z_q, 1'b0});
              mul_go_q <= 1'b1;
              state_q  <= S_SER_MUL;
            end
          end
        end
        S_ZB: begin
          if (mul_done) begin
            zb_q     <= zb_n;
            fi_q     <= fi_first;
            rat_q    <= '0;
            div_n_q  <= {3'b0, efu_pkg::FIT_NUM[fi_first], 32'b0};
            div_d_q  <= efu_pkg::DIV_D_W'(efu_pkg::FIT_DEN[fi_first]) +
                        efu_pkg::DIV_D_W'(zb_n);
            div_go_q <= 1'b1;
            state_q  <= S_FIT_DIV;
          end
        end
        S_FIT_DIV: begin
          if (div_done) begin
            rat_q <= rat_n;
            if (fi_q == efu_pkg::FIT_MID_LAST || fi_q == efu_pkg::FIT_FAR_LAST) begin
              mul_a_q  <= efu_pkg::MUL_A_W'(rat_n);
              mul_b_q  <= efu_pkg::MUL_B_W'(e_q);
              mul_go_q <= 1'b1;
              state_q  <= S_W1;
            end else begin
              fi_q     <= fi_q + 3'd1;
              div_n_q  <= {3'b0, efu_pkg::FIT_NUM[fi_q + 3'd1], 32'b0};
              div_d_q  <= efu_pkg::DIV_D_W'(efu_pkg::FIT_DEN[fi_q + 3'd1]) +
                          efu_pkg::DIV_D_W'(zb_q);
              div_go_q <= 1'b1;
            end
          end
        end
        S_W1: begin
          if (mul_done) begin
            mul_a_q  <= efu_pkg::MUL_A_W'(ax_q);
            mul_b_q  <= efu_pkg::MUL_B_W'(mul_p >> 32);
            mul_go_q <= 1'b1;
            state_q  <= S_W2;
          end
        end
        S_W2: begin
          if (mul_done) begin
            v_q     <= v_fit;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          // Hand the item to the output register once it is free
          if (!out_valid_q || !out_stall_i) begin
            value_q     <= value_n;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

`ifndef SYNTH
  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_go_q && div_go_q))
    else $error("multiplier and divider started together");

  a_mul_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_SQ || state_q == S_EXP_MUL || state_q == S_POW ||
                  state_q == S_R0A || state_q == S_R0B || state_q == S_SER_MUL ||
                  state_q == S_ZB || state_q == S_W1 || state_q == S_W2))
    else $error("multiplier result with no consumer");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_EXP_DIV || state_q == S_SER_DIV || state_q == S_FIT_DIV))
    else $error("divider result with no consumer");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && out_stall_i) |=> state_q == S_OUT)
    else $error("result dropped while output held");
`endif

endmodule

[tb/sv/error_function_unit_tb.sv]
`timescale 1ns / 1ps

module error_function_unit_tb;

  localparam longint unsigned Q32_ONE = 64'h1_0000_0000;
  localparam longint unsigned K_2SQPI = 64'd4846351620;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [15:0] argument_i;
  logic               complementary_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [17:0] value_o;

  error_function_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .argument_i      (argument_i),
    .complementary_i (complementary_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .value_o         (value_o)
  );

  logic [17:0] value_due[$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned recv_hold_cycles;
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned results_seen;

  // Clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // e^-f for a 24-bit fraction f, alternating Taylor sum in Q.32
  function automatic longint unsigned exp_frac_q32(longint unsigned f);
    longint sum;
    longint unsigned t;
    sum = longint'(Q32_ONE);
    t = Q32_ONE;
    for (int k = 1; k <= 16; k++) begin
      t = ((t * f) >> 24) / longint'(k);
      if (k % 2 == 1) sum = sum - longint'(t);
      else sum = sum + longint'(t);
    end
    if (sum < 0) sum = 0;
    return longint'(sum);
  endfunction

  // e^-z for z with 24 fraction bits
  function automatic longint unsigned exp_neg_q32(longint unsigned z24);
    longint unsigned whole;
    longint unsigned e;
    longint unsigned e1;
    whole = z24 >> 24;
    e = exp_frac_q32(z24 & 64'hFF_FFFF);
    e1 = exp_frac_q32(64'h100_0000);
    for (longint unsigned j = 0; j < whole && e != 0; j++) e = (e * e1) >> 32;
    return e;
  endfunction

  function automatic longint unsigned fit_quot(longint unsigned num, longint unsigned den,
                                               longint unsigned z24);
    longint unsigned d;
    d = den + ((z24 * 64'd1000000000) >> 24);
    return (num << 32) / d;
  endfunction

  // Round Q.32 to Q2.16, ties away from zero, saturate
  function automatic logic [17:0] round_q216(longint v);
    longint unsigned m;
    longint q;
    m = (v < 0) ? longint'(-v) : longint'(v);
    q = longint'((m + 64'd32768) >> 16);
    if (v < 0) q = -q;
    if (q > 131071) q = 131071;
    if (q < -131072) q = -131072;
    return q[17:0];
  endfunction

  function automatic logic [17:0] erf_value(logic signed [15:0] x, logic comp);
    longint xs;
    longint unsigned ax, z24, e, r, s, rat, w;
    longint v, serf;
    xs = x;
    ax = (xs < 0) ? longint'(-xs) : longint'(xs);
    z24 = ax * ax;
    e = exp_neg_q32(z24);
    if (ax <= 12288) begin
      r = (((ax * e) >> 12) * K_2SQPI) >> 32;
      s = r;
      for (int k = 1; k < 48; k++) begin
        r = (r * (2 * z24)) / ((longint'(2 * k + 1)) << 24);
        s = s + r;
      end
      serf = (xs < 0) ? -longint'(s) : longint'(s);
      v = comp ? longint'(Q32_ONE) - serf : serf;
    end else begin
      if (ax <= 24576)
        rat = fit_quot(461313500, 190163500, z24) + fit_quot(99992160, 1784492700, z24)
            + fit_quot(2883894, 64'd5525343700, z24);
      else
        rat = fit_quot(512424200, 275255100, z24) + fit_quot(51765360, 64'd2724745000, z24);
      w = (ax * ((rat * e) >> 32)) >> 12;
      if (xs > 0) v = comp ? longint'(w) : longint'(Q32_ONE) - longint'(w);
      else v = comp ? 2 * longint'(Q32_ONE) - longint'(w) : longint'(w) - longint'(Q32_ONE);
    end
    return round_q216(v);
  endfunction

  // Offer one item after an optional gap, hold it until accepted
  task automatic send_item(logic signed [15:0] x, logic comp);
    bit idle;
    idle = ($urandom_range(99) < send_idle_pct);
    if (idle) in_valid_i <= 1'b0;
    while (idle) begin
      @(posedge clk_i);
      idle = ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    argument_i <= x;
    complementary_i <= comp;
    do @(posedge clk_i); while (in_stall_o);
    value_due.push_back(erf_value(x, comp));
    items_sent++;
  endtask

  // Drop valid and wait until every expected result has come
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (value_due.size() != 0) @(posedge clk_i);
  endtask

  // Check results and drive the stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (value_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %0d", value_o);
        end else begin
          if (value_o !== value_due[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("value mismatch: expected %0d actual %0d",
                       $signed(value_due[0]), value_o);
          end
          void'(value_due.pop_front());
        end
      end
      if (recv_hold_cycles != 0) begin
        recv_hold_cycles <= recv_hold_cycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic test_edges();
    logic signed [15:0] pts[11];
    pts = '{16'sd0, 16'sd1, -16'sd1, 16'sd12288, -16'sd12288, 16'sd12289, -16'sd12289,
            16'sd24576, 16'sd24577, 16'sd32767, -16'sd32768};
    foreach (pts[i]) begin
      send_item(pts[i], 1'b0);
      send_item(pts[i], 1'b1);
    end
  endtask

  // Random mix: series range most often, middle fit range and any code less often
  task automatic test_random(int unsigned n);
    logic signed [15:0] x;
    int unsigned sel;
    for (int unsigned i = 0; i < n; i++) begin
      sel = $urandom_range(9);
      if (sel < 4) x = 16'($urandom_range(24576) - 12288);
      else if (sel < 7) x = 16'($urandom_range(12288) + 12289);
      else x = 16'($urandom);
      if (sel inside {4, 5, 6} && $urandom_range(1)) x = -x;
      send_item(x, 1'($urandom_range(1)));
    end
  endtask

  // Receiver holds off while items keep coming, then sender waits for drain
  task automatic test_backpressure();
    recv_hold_cycles = 30000;
    for (int i = 0; i < 4; i++) send_item(16'($urandom), 1'($urandom_range(1)));
    wait_drained();
    repeat (20) @(posedge clk_i);
    send_item(16'sd4096, 1'b1);
    wait_drained();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    argument_i = '0;
    complementary_i = 1'b0;
    out_stall_i = 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 72;
    recv_hold_cycles = 0;
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edges();
    test_backpressure();
    test_random(500);
    send_idle_pct = 72;
    recv_idle_pct = 7;
    test_random(500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(520);
    wait_drained();
    repeat (200) @(posedge clk_i);
    $display("sent %0d items across erf and erfc, series and both fit ranges", items_sent);
    $display("checked %0d results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && value_due.size() == 0) begin
      $display("error_function_unit test passed");
    end else begin
      $display("error_function_unit test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(64'd120_000_000);
    $display("error_function_unit test failed");
    $finish;
  end

endmodule
